FILE: sv/bls_pkg.sv
// ============================================================================
// bls_pkg
// Shared types and constants for the Bresenham line stepper.
// ============================================================================
package bls_pkg;

  // Coordinate width and the width of the error term and its increments.
  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int COLOR_BITS = 32;

  // Configuration port: one 32-bit register at byte address 0.
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam int REG_BITS  = ADDR_BITS - 2;
  localparam logic [REG_BITS-1:0] REG_DEFAULT_COLOR = REG_BITS'(0);

  // Operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Color modes. Codes with the upper bit set trace without drawing.
  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_ITEM    = 2'd1;
  localparam logic [1:0] MODE_TRACE   = 2'd2;

  typedef struct packed {
    logic                          operation;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic [COLOR_BITS-1:0]         line_color;
    logic [1:0]                    color_mode;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic [COLOR_BITS-1:0]         pixel_color;
    logic                          last_pixel;
  } pixel_t;

  // Line parameters produced by the setup logic for a load transaction.
  typedef struct packed {
    logic                          x_negative;
    logic                          y_negative;
    logic                          major_is_x;
    logic signed [ERR_BITS-1:0]    error_term;
    logic signed [ERR_BITS-1:0]    inc_straight;
    logic signed [ERR_BITS-1:0]    inc_diagonal;
    logic [COORD_BITS-1:0]         steps_left;
  } line_setup_t;

endpackage

FILE: sv/bls_cfg_regs.sv
// ============================================================================
// bls_cfg_regs
// APB register block holding the default pixel color.
// ============================================================================
module bls_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bls_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [bls_pkg::DATA_BITS-1:0]  pwdata,
  output logic [bls_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output logic [bls_pkg::COLOR_BITS-1:0] default_color
);

  logic [bls_pkg::REG_BITS-1:0] reg_index;

  assign reg_index = paddr[bls_pkg::ADDR_BITS-1:2];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (reg_index == bls_pkg::REG_DEFAULT_COLOR)) begin
      default_color <= pwdata;
    end
  end

  always_comb begin
    unique case (reg_index)
      bls_pkg::REG_DEFAULT_COLOR: prdata = default_color;
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: sv/bls_line_setup.sv
// ============================================================================
// bls_line_setup
// Derives deltas, step directions, major axis and error terms of a new line.
// ============================================================================
module bls_line_setup (
  input  logic signed [bls_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [bls_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [bls_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [bls_pkg::COORD_BITS-1:0] end_y,
  output bls_pkg::line_setup_t                  setup
);

  localparam int CB = bls_pkg::COORD_BITS;

  logic signed [CB:0] diff_x;
  logic signed [CB:0] diff_y;
  logic [CB:0]        neg_x;
  logic [CB:0]        neg_y;
  logic [CB-1:0]      dx;
  logic [CB-1:0]      dy;
  logic [CB-1:0]      major;
  logic [CB-1:0]      minor;
  logic               major_is_x;

  always_comb begin
    // One extra bit keeps the endpoint difference exact.
    diff_x = $signed({end_x[CB-1], end_x}) - $signed({start_x[CB-1], start_x});
    diff_y = $signed({end_y[CB-1], end_y}) - $signed({start_y[CB-1], start_y});
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    dx     = diff_x[CB] ? neg_x[CB-1:0] : diff_x[CB-1:0];
    dy     = diff_y[CB] ? neg_y[CB-1:0] : diff_y[CB-1:0];

    major_is_x = dy < dx;
    major      = major_is_x ? dx : dy;
    minor      = major_is_x ? dy : dx;

    setup.x_negative   = diff_x[CB];
    setup.y_negative   = diff_y[CB];
    setup.major_is_x   = major_is_x;
    setup.inc_straight = $signed({1'b0, minor, 1'b0});
    setup.error_term   = $signed({1'b0, minor, 1'b0}) - $signed({2'b00, major});
    setup.inc_diagonal = $signed({1'b0, minor, 1'b0}) - $signed({1'b0, major, 1'b0});
    setup.steps_left   = major;
  end

endmodule

FILE: sv/bls_line_core.sv
// ============================================================================
// bls_line_core
// Line state registers and the per-transaction load and step update.
// ============================================================================
module bls_line_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  bls_pkg::item_t                 item,
  input  bls_pkg::line_setup_t           setup,
  input  logic [bls_pkg::COLOR_BITS-1:0] default_color,
  output logic                           emit,
  output bls_pkg::pixel_t                result
);

  localparam int CB = bls_pkg::COORD_BITS;
  localparam int EB = bls_pkg::ERR_BITS;

  logic                          active;
  logic signed [CB-1:0]          cur_x;
  logic signed [CB-1:0]          cur_y;
  logic signed [EB-1:0]          error_term;
  logic signed [EB-1:0]          inc_straight;
  logic signed [EB-1:0]          inc_diagonal;
  logic                          x_negative;
  logic                          y_negative;
  logic                          major_is_x;
  logic [CB-1:0]                 steps_left;
  logic [bls_pkg::COLOR_BITS-1:0] held_color;
  logic [1:0]                    held_mode;

  logic                          active_next;
  logic signed [CB-1:0]          cur_x_next;
  logic signed [CB-1:0]          cur_y_next;
  logic signed [EB-1:0]          error_term_next;
  logic [CB-1:0]                 steps_left_next;
  logic [bls_pkg::COLOR_BITS-1:0] held_color_next;
  logic [1:0]                    held_mode_next;

  logic                          is_load;
  logic                          diag;
  logic signed [CB-1:0]          step_x;
  logic signed [CB-1:0]          step_y;
  logic                          move_x;
  logic                          move_y;

  assign is_load = (item.operation == bls_pkg::OP_LOAD);

  always_comb begin
    // Move the minor axis only when the error is strictly positive.
    diag   = !error_term[EB-1] && (error_term != '0);
    step_x = x_negative ? '1 : CB'(1);
    step_y = y_negative ? '1 : CB'(1);
    move_x = major_is_x || diag;
    move_y = !major_is_x || diag;

    if (is_load) begin
      active_next     = (setup.steps_left != '0);
      cur_x_next      = item.start_x;
      cur_y_next      = item.start_y;
      error_term_next = setup.error_term;
      steps_left_next = setup.steps_left;
      held_color_next = item.line_color;
      held_mode_next  = item.color_mode;
    end else begin
      cur_x_next      = move_x ? cur_x + step_x : cur_x;
      cur_y_next      = move_y ? cur_y + step_y : cur_y;
      error_term_next = error_term + (diag ? inc_diagonal : inc_straight);
      steps_left_next = steps_left - CB'(1);
      active_next     = (steps_left_next != '0);
      held_color_next = held_color;
      held_mode_next  = held_mode;
    end
  end

  always_comb begin
    emit = fire && (is_load || active) && !held_mode_next[1];
    result.pixel_x     = cur_x_next;
    result.pixel_y     = cur_y_next;
    result.pixel_color = (held_mode_next == bls_pkg::MODE_DEFAULT) ? default_color
                                                                   : held_color_next;
    result.last_pixel  = (steps_left_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (fire && (is_load || active)) begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_load) begin
      inc_straight <= setup.inc_straight;
      inc_diagonal <= setup.inc_diagonal;
      x_negative   <= setup.x_negative;
      y_negative   <= setup.y_negative;
      major_is_x   <= setup.major_is_x;
    end
    if (fire && (is_load || active)) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= error_term_next;
      steps_left <= steps_left_next;
      held_color <= held_color_next;
      held_mode  <= held_mode_next;
    end
  end

endmodule

FILE: sv/bresenham_line_stepper.sv
// ============================================================================
// bresenham_line_stepper
// Integer Bresenham line rasterizer: a load transaction sets up a line and
// yields its start pixel, each step on an active line the next; trace modes none.
// ============================================================================
// Path: a transaction accepted into the input register passes through the line
// update into the output register, where its pixel is presented.
// Throughput: one transaction per cycle; the line update is a single add on
// the error term and coordinates, and only a stalled pixel holds the input.
// Reset (rst, synchronous): no line active, both pipeline registers empty,
// default color register zero.
// ============================================================================
module bresenham_line_stepper (
  input  logic                           clk,
  input  logic                           rst,

  // Transaction input channel.
  input  logic                           item_valid,
  output logic                           item_stall,
  input  bls_pkg::item_t                 item,

  // Pixel output channel.
  output logic                           pixel_valid,
  input  logic                           pixel_stall,
  output bls_pkg::pixel_t                pixel,

  // APB configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bls_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [bls_pkg::DATA_BITS-1:0]  pwdata,
  output logic [bls_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);

  // Input register. A transaction sits here while the line core computes its
  // result from the current line state.
  logic                           in_valid;
  bls_pkg::item_t                 in_item;

  logic                           advance;
  logic                           emit;
  bls_pkg::pixel_t                result;
  bls_pkg::line_setup_t           setup;
  logic [bls_pkg::COLOR_BITS-1:0] default_color;

  // The held transaction moves on when the output register is empty or is
  // being emptied in this cycle. Transactions that make no pixel also wait
  // for that, which keeps the control simple and costs nothing in rate
  // while the consumer keeps up.
  assign advance    = in_valid && (!pixel_valid || !pixel_stall);

  // A new transaction can enter whenever the input register is empty or is
  // draining in this same cycle.
  assign item_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      in_item <= item;
    end
  end

  bls_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .default_color (default_color)
  );

  // Setup math for load transactions: deltas, directions, major axis and
  // the initial error term with its two increments.
  bls_line_setup u_setup (
    .start_x (in_item.start_x),
    .start_y (in_item.start_y),
    .end_x   (in_item.end_x),
    .end_y   (in_item.end_y),
    .setup   (setup)
  );

  // Line state and the per-pixel update. The default color is sampled when
  // each pixel is produced, so a register write between lines is seen by
  // every later pixel of a default color mode line.
  bls_line_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .item          (in_item),
    .setup         (setup),
    .default_color (default_color),
    .emit          (emit),
    .result        (result)
  );

  // Output register. It holds a finished pixel while the consumer stalls,
  // and is refilled in the same cycle that it is emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance && emit) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      pixel <= result;
    end
  end

endmodule
